// File: src/ntd_pkg.sv
package ntd_pkg;

   // Stack geometry and field widths.
   localparam int MAX_DEPTH = 8;
   localparam int WORD_W    = 16;
   localparam int DEPTH_W   = 4;
   localparam int KIND_W    = 3;
   localparam int PHASE_W   = 3;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register indexes, taken from the word address.
   localparam logic REG_NESTED_TYPE = 1'b0;
   localparam logic REG_BIG_ENDIAN  = 1'b1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_RECORD     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RECORD_END = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAN_END  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TRUNCATED  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NEST_ERROR = 3'd4;

   // Parser phases: four header bytes, then the body of a plain value.
   localparam logic [PHASE_W-1:0] PH_TYPE_0 = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LEN_1  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_VALUE  = 3'd4;

   // Configuration register values.
   typedef struct packed {
      logic [WORD_W-1:0] nested_type;
      logic              big_endian;
   } cfg_type;

   // Control broadcast to every stack cell.
   typedef struct packed {
      logic              clear;
      logic              push;
      logic              pop;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] push_end;
   } cell_ctl_type;

   // Status returned by each stack cell.
   typedef struct packed {
      logic              occ;
      logic              occ_next;
      logic              hit;
      logic              top;
      logic [WORD_W-1:0] top_end;
   } cell_stat_type;

   // One result beat.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [WORD_W-1:0]  record_type;
      logic [WORD_W-1:0]  record_length;
      logic [WORD_W-1:0]  value_offset;
      logic [DEPTH_W-1:0] nest_depth;
   } rsp_beat_type;

endpackage

// File: src/ntd_channels.sv
// Input channel: one buffer byte per beat.
interface ntd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel: one reported record or buffer status per beat.
interface ntd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ntd_pkg::KIND_W-1:0]   kind;
   logic [ntd_pkg::WORD_W-1:0]   record_type;
   logic [ntd_pkg::WORD_W-1:0]   record_length;
   logic [ntd_pkg::WORD_W-1:0]   value_offset;
   logic [ntd_pkg::DEPTH_W-1:0]  nest_depth;

   modport source (output valid, output kind, output record_type, output record_length,
                   output value_offset, output nest_depth, input ready);
   modport sink   (input valid, input kind, input record_type, input record_length,
                   input value_offset, input nest_depth, output ready);
endinterface

// File: src/nested_tlv_deframer_unit.sv
// Record deframer for byte streams. It takes one buffer byte per cycle while the input is not
// stalled, and reports each record header (type, length, value offset, nesting depth) decoded
// at its last header byte; buffer end status and errors come out the same way. Open nested values
// are held in a row of MAX_DEPTH stack cells that each compare their end offset against the
// current offset in parallel, so every level closing on a byte is popped in that byte's
// cycle. Results pass through an output register and a one-beat skid stage; the input stalls
// only while the skid stage holds a beat. Configuration registers: nested_type at byte
// address 0 (reset 0xFFFF) and big_endian at byte address 4 (reset 0, little-endian).
module nested_tlv_deframer_unit (
   input  logic                              clock,
   input  logic                              reset,
   ntd_req_if.sink                           req_chan,
   ntd_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ntd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ntd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ntd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int N = ntd_pkg::MAX_DEPTH;

   ntd_pkg::cfg_type       cfg;
   ntd_pkg::cell_ctl_type  ctl;
   ntd_pkg::cell_stat_type stat [N];
   ntd_pkg::rsp_beat_type  beat;
   logic                   beat_valid;
   logic                   space;
   logic                   accept;

   logic [ntd_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [ntd_pkg::WORD_W-1:0]  type_hold_ff, type_hold_in;
   logic [ntd_pkg::WORD_W-1:0]  len_hold_ff, len_hold_in;
   logic [ntd_pkg::WORD_W-1:0]  offset_ff, offset_in;
   logic [ntd_pkg::WORD_W-1:0]  vleft_ff, vleft_in;
   logic                        err_ff, err_in;

   logic [ntd_pkg::PHASE_W-1:0] phase_n;
   logic [ntd_pkg::WORD_W-1:0]  type_n, len_n, off_n, vleft_n, remain, top_end;
   logic [N-1:0]                occ, occ_next, top_hit;
   logic [ntd_pkg::DEPTH_W-1:0] level_now, level_next;
   logic in_header, hdr_done, hi_byte, len_err, nest, full_err, push, plain;
   logic pop_err, err, rec, clean;

   ntd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Row of stack cells, bottom level in cell 0.
   for (genvar k = 0; k < N; k++) begin : g_cell
      logic below, above;
      if (k == 0) begin : g_bot
         assign below = 1'b1;
      end else begin : g_mid_b
         assign below = stat[k-1].occ;
      end
      if (k == N - 1) begin : g_top
         assign above = 1'b0;
      end else begin : g_mid_a
         assign above = stat[k+1].occ;
      end
      ntd_stack_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .occ_below (below),
         .occ_above (above),
         .stat      (stat[k])
      );
   end

   // Gather cell status.
   always_comb begin
      top_end = '0;
      for (int k = 0; k < N; k++) begin
         occ[k]      = stat[k].occ;
         occ_next[k] = stat[k].occ_next;
         top_hit[k]  = stat[k].top & stat[k].hit;
         top_end     = top_end | stat[k].top_end;
      end
      level_now  = ntd_pkg::DEPTH_W'($countones(occ));
      level_next = ntd_pkg::DEPTH_W'($countones(occ_next));
   end

   assign accept = req_chan.valid & req_chan.ready;
   assign req_chan.ready = space;

   // Header assembly and record decisions for the byte at the input.
   always_comb begin
      off_n     = offset_ff + 16'd1;
      in_header = (phase_ff != ntd_pkg::PH_VALUE);
      hdr_done  = (phase_ff == ntd_pkg::PH_LEN_1);
      // Bit 0 of the phase picks the second byte of a field, bit 1 the length field.
      hi_byte   = phase_ff[0] ^ cfg.big_endian;
      type_n    = type_hold_ff;
      len_n     = len_hold_ff;
      if (in_header && !phase_ff[1]) begin
         if (hi_byte) type_n[15:8] = req_chan.data_byte;
         else         type_n[7:0]  = req_chan.data_byte;
      end
      if (in_header && phase_ff[1]) begin
         if (hi_byte) len_n[15:8] = req_chan.data_byte;
         else         len_n[7:0]  = req_chan.data_byte;
      end

      remain   = top_end - off_n;
      len_err  = hdr_done & occ[0] & (len_n > remain);
      nest     = hdr_done & ~len_err & (type_n == cfg.nested_type) & (len_n != '0);
      full_err = nest & occ[N-1];
      push     = nest & ~occ[N-1];
      plain    = hdr_done & ~len_err & ~nest;
      rec      = push | plain;

      vleft_n = vleft_ff;
      if (in_header) begin
         phase_n = phase_ff + 3'd1;
         if (push) begin
            phase_n = ntd_pkg::PH_TYPE_0;
         end else if (plain) begin
            vleft_n = len_n;
            phase_n = (len_n != '0) ? ntd_pkg::PH_VALUE : ntd_pkg::PH_TYPE_0;
         end
      end else begin
         vleft_n = vleft_ff - 16'd1;
         phase_n = (vleft_n == '0) ? ntd_pkg::PH_TYPE_0 : ntd_pkg::PH_VALUE;
      end

      // A level that closes inside a header or a value body is an overrun.
      pop_err = ~len_err & ~full_err & (|top_hit) & (phase_n != ntd_pkg::PH_TYPE_0);
      err     = len_err | full_err | pop_err;
      clean   = (phase_n == ntd_pkg::PH_TYPE_0) & ~occ_next[0];
   end

   // Stack control: push and pop only on an accepted byte of a live buffer, clear on the last byte.
   always_comb begin
      ctl.clear    = accept & req_chan.last_byte;
      ctl.push     = accept & ~err_ff & push;
      ctl.pop      = accept & ~err_ff & ~err;
      ctl.offset   = off_n;
      ctl.push_end = off_n + len_n;
   end

   // Result selection.
   always_comb begin
      beat.kind          = ntd_pkg::KIND_RECORD;
      beat.record_type   = type_n;
      beat.record_length = len_n;
      beat.value_offset  = off_n;
      beat.nest_depth    = level_now;
      beat_valid         = 1'b0;
      if (accept && !err_ff) begin
         if (err) begin
            beat.kind  = ntd_pkg::KIND_NEST_ERROR;
            beat_valid = 1'b1;
         end else if (req_chan.last_byte) begin
            beat_valid = 1'b1;
            if (clean && rec) begin
               beat.kind = ntd_pkg::KIND_RECORD_END;
            end else begin
               beat.kind          = clean ? ntd_pkg::KIND_CLEAN_END : ntd_pkg::KIND_TRUNCATED;
               beat.record_type   = '0;
               beat.record_length = '0;
               beat.nest_depth    = clean ? '0 : level_next;
            end
         end else begin
            beat_valid = rec;
         end
      end
   end

   // Parser state update; the last byte returns the buffer state to reset.
   always_comb begin
      phase_in     = phase_ff;
      type_hold_in = type_hold_ff;
      len_hold_in  = len_hold_ff;
      offset_in    = offset_ff;
      vleft_in     = vleft_ff;
      err_in       = err_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            phase_in     = ntd_pkg::PH_TYPE_0;
            type_hold_in = '0;
            len_hold_in  = '0;
            offset_in    = '0;
            vleft_in     = '0;
            err_in       = 1'b0;
         end else if (!err_ff) begin
            phase_in     = phase_n;
            type_hold_in = type_n;
            len_hold_in  = len_n;
            offset_in    = off_n;
            vleft_in     = vleft_n;
            err_in       = err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ntd_pkg::PH_TYPE_0;
         type_hold_ff <= '0;
         len_hold_ff  <= '0;
         offset_ff    <= '0;
         vleft_ff     <= '0;
         err_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         type_hold_ff <= type_hold_in;
         len_hold_ff  <= len_hold_in;
         offset_ff    <= offset_in;
         vleft_ff     <= vleft_in;
         err_ff       <= err_in;
      end
   end

   ntd_out_skid u_out (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .space      (space),
      .rsp        (rsp_chan)
   );

endmodule

// File: src/ntd_csr.sv
module ntd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ntd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ntd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ntd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output ntd_pkg::cfg_type                  cfg
);

   logic [ntd_pkg::WORD_W-1:0] nested_type_ff, nested_type_in;
   logic                       big_endian_ff, big_endian_in;
   logic                       wr_en;
   logic                       reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel & penable & pwrite;

   // Register writes in the access cycle.
   always_comb begin
      nested_type_in = nested_type_ff;
      big_endian_in  = big_endian_ff;
      if (wr_en) begin
         case (reg_idx)
            ntd_pkg::REG_NESTED_TYPE: nested_type_in = pwdata[ntd_pkg::WORD_W-1:0];
            ntd_pkg::REG_BIG_ENDIAN:  big_endian_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nested_type_ff <= '1;
         big_endian_ff  <= 1'b0;
      end else begin
         nested_type_ff <= nested_type_in;
         big_endian_ff  <= big_endian_in;
      end
   end

   // Read data follows the address.
   always_comb begin
      prdata = '0;
      case (reg_idx)
         ntd_pkg::REG_NESTED_TYPE: prdata[ntd_pkg::WORD_W-1:0] = nested_type_ff;
         ntd_pkg::REG_BIG_ENDIAN:  prdata[0] = big_endian_ff;
         default: ;
      endcase
   end

   assign cfg.nested_type = nested_type_ff;
   assign cfg.big_endian  = big_endian_ff;

endmodule

// File: src/ntd_stack_cell.sv
module ntd_stack_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  ntd_pkg::cell_ctl_type   ctl,
   input  logic                    occ_below,
   input  logic                    occ_above,
   output ntd_pkg::cell_stat_type  stat
);

   logic                       occ_ff, occ_in;
   logic [ntd_pkg::WORD_W-1:0] end_ff, end_in;
   logic                       hit;
   logic                       push_here;
   logic                       occ_keep;

   // This cell is the free slot just above the occupied run.
   assign push_here = ctl.push & ~occ_ff & occ_below;
   assign hit       = occ_ff & (end_ff == ctl.offset);

   // Push fills the free slot, pop drops every level whose value ends here.
   always_comb begin
      occ_keep = occ_ff;
      if (push_here) begin
         occ_keep = 1'b1;
      end else if (ctl.pop && hit) begin
         occ_keep = 1'b0;
      end
      occ_in = occ_keep & ~ctl.clear;
      end_in = push_here ? ctl.push_end : end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff <= end_in;
   end

   assign stat.occ      = occ_ff;
   assign stat.occ_next = occ_keep;
   assign stat.hit      = hit;
   assign stat.top      = occ_ff & ~occ_above;
   assign stat.top_end  = (occ_ff & ~occ_above) ? end_ff : '0;

endmodule

// File: src/ntd_out_skid.sv
module ntd_out_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat_valid,
   input  ntd_pkg::rsp_beat_type  beat,
   output logic                   space,
   ntd_rsp_if.source              rsp
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   ntd_pkg::rsp_beat_type out_ff, out_in;
   ntd_pkg::rsp_beat_type skid_ff, skid_in;
   logic                  out_free;

   assign space    = ~skid_valid_ff;
   assign out_free = ~out_valid_ff | rsp.ready;

   // The output register refills from the skid first, then from a new beat.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = beat;
            out_valid_in = beat_valid;
         end
      end else if (beat_valid) begin
         skid_in       = beat;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.kind          = out_ff.kind;
   assign rsp.record_type   = out_ff.record_type;
   assign rsp.record_length = out_ff.record_length;
   assign rsp.value_offset  = out_ff.value_offset;
   assign rsp.nest_depth    = out_ff.nest_depth;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ntd_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 280;
   localparam rsp_beat_type NO_BEAT = '0;

   // One row of the opening stimulus table.
   typedef struct {
      logic [7:0]   data;
      bit           last;
      bit           typed;
      rsp_beat_type want;
   } byte_case_type;

   logic clock;
   logic reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ntd_req_if req_chan ();
   ntd_rsp_if rsp_chan ();

   nested_tlv_deframer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Mirror of the deframer state and its registers.
   cfg_type            csr_model;
   logic [PHASE_W-1:0] hdr_phase;
   logic [WORD_W-1:0]  type_acc;
   logic [WORD_W-1:0]  len_acc;
   logic [WORD_W-1:0]  buf_offset;
   logic [WORD_W-1:0]  body_left;
   logic [WORD_W-1:0]  open_end [MAX_DEPTH];
   logic [DEPTH_W-1:0] open_levels;
   bit                 skipping;

   rsp_beat_type due_results [$];
   logic [7:0]   frame_q [$];
   int           failures = 0;
   int           items_sent = 0;
   int           tx_idle_pct = 0;
   int           rx_stall_pct = 0;
   int           long_hold_len = 0;

   // Hand-checked opening bytes, reset register values (nested type 0xFFFF, little-endian).
   byte_case_type opening_bytes [26] = '{
      // Empty record whose header ends on the last byte.
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b1, 1'b1, '{KIND_RECORD_END, 16'h0000, 16'h0000, 16'd4, 4'd0}},
      // Nested record holding one inner record, closing on the last byte.
      '{8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{8'h05, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h07, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h55, 1'b1, 1'b1, '{KIND_CLEAN_END, 16'h0000, 16'h0000, 16'd9, 4'd0}},
      // Inner record longer than its parent, then ignored bytes up to the last one.
      '{8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{8'h06, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h09, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b1, '{KIND_NEST_ERROR, 16'h0001, 16'd9, 16'd8, 4'd1}},
      '{8'hAA, 1'b1, 1'b0, NO_BEAT},
      // Widest header fields with the value cut off by the last byte.
      '{8'hFE, 1'b0, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{8'hFF, 1'b1, 1'b1, '{KIND_TRUNCATED, 16'h0000, 16'h0000, 16'd4, 4'd0}}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("nested_tlv_deframer_unit regression: fail");
      $finish;
   end

   // Return the per-buffer state to its idle values.
   function automatic void clear_frame_state();
      hdr_phase   = PH_TYPE_0;
      type_acc    = '0;
      len_acc     = '0;
      buf_offset  = '0;
      body_left   = '0;
      open_levels = '0;
      skipping    = 1'b0;
   endfunction

   // Advance the deframer by one byte and give the result beat it causes, if any.
   function automatic void deframe_byte(input logic [7:0] b, input bit last,
                                        output bit has, output rsp_beat_type r);
      bit                 fault;
      bit                 got_rec;
      bit                 hi;
      logic [WORD_W-1:0]  rt;
      logic [WORD_W-1:0]  rl;
      logic [WORD_W-1:0]  ro;
      logic [WORD_W-1:0]  room;
      logic [DEPTH_W-1:0] rd;
      has = 1'b0;
      r = NO_BEAT;
      fault = 1'b0;
      got_rec = 1'b0;
      rt = '0;
      rl = '0;
      ro = '0;
      rd = '0;
      room = '0;

      // After a nesting error, bytes are dropped until the buffer ends.
      if (skipping) begin
         if (last) clear_frame_state();
         return;
      end
      buf_offset = buf_offset + 16'd1;

      if (hdr_phase < PH_VALUE) begin
         // Odd header bytes are the high half in little-endian order.
         hi = hdr_phase[0] ^ csr_model.big_endian;
         if (!hdr_phase[1]) begin
            if (hi) type_acc[15:8] = b;
            else type_acc[7:0] = b;
         end else begin
            if (hi) len_acc[15:8] = b;
            else len_acc[7:0] = b;
         end
         hdr_phase = hdr_phase + 3'd1;
         if (hdr_phase == PH_VALUE) begin
            rt = type_acc;
            rl = len_acc;
            ro = buf_offset;
            rd = open_levels;
            if (open_levels > 0) room = open_end[open_levels - 4'd1] - buf_offset;
            if (open_levels > 0 && len_acc > room) begin
               fault = 1'b1;
            end else if (type_acc == csr_model.nested_type && len_acc != 0) begin
               if (open_levels >= MAX_DEPTH) begin
                  fault = 1'b1;
               end else begin
                  open_end[open_levels] = buf_offset + len_acc;
                  open_levels = open_levels + 4'd1;
                  hdr_phase = PH_TYPE_0;
                  got_rec = 1'b1;
               end
            end else begin
               body_left = len_acc;
               hdr_phase = (len_acc != 0) ? PH_VALUE : PH_TYPE_0;
               got_rec = 1'b1;
            end
         end
      end else begin
         body_left = body_left - 16'd1;
         if (body_left == 0) hdr_phase = PH_TYPE_0;
      end

      // Close every nested level that ends on this byte.
      while (!fault && open_levels > 0 && open_end[open_levels - 4'd1] == buf_offset) begin
         if (hdr_phase != PH_TYPE_0) begin
            fault = 1'b1;
            rt = type_acc;
            rl = len_acc;
            ro = buf_offset;
            rd = open_levels;
         end else begin
            open_levels = open_levels - 4'd1;
         end
      end

      if (fault) begin
         has = 1'b1;
         r = '{KIND_NEST_ERROR, rt, rl, ro, rd};
         skipping = 1'b1;
         if (last) clear_frame_state();
         return;
      end

      if (last) begin
         has = 1'b1;
         if (hdr_phase == PH_TYPE_0 && open_levels == 0 && got_rec)
            r = '{KIND_RECORD_END, rt, rl, ro, rd};
         else if (hdr_phase == PH_TYPE_0 && open_levels == 0)
            r = '{KIND_CLEAN_END, 16'h0000, 16'h0000, buf_offset, 4'd0};
         else
            r = '{KIND_TRUNCATED, 16'h0000, 16'h0000, buf_offset, open_levels};
         clear_frame_state();
         return;
      end

      if (got_rec) begin
         has = 1'b1;
         r = '{KIND_RECORD, rt, rl, ro, rd};
      end
   endfunction

   // Place a 16-bit header field in the frame in the current byte order.
   function automatic void put_word(input int at, input logic [15:0] w);
      if (csr_model.big_endian) begin
         frame_q[at]     = w[15:8];
         frame_q[at + 1] = w[7:0];
      end else begin
         frame_q[at]     = w[7:0];
         frame_q[at + 1] = w[15:8];
      end
   endfunction

   // Append one well-formed record, nesting further with the given chance.
   function automatic void add_record(input int level, input int nest_pct);
      int          start;
      int          kids;
      int          len;
      logic [15:0] code;
      start = frame_q.size();
      repeat (4) frame_q = {frame_q, 8'h00};
      if (level < 10 && $urandom_range(99) < nest_pct) begin
         put_word(start, csr_model.nested_type);
         kids = (level < 2) ? $urandom_range(0, 2) : (($urandom_range(9) == 0) ? 0 : 1);
         repeat (kids) add_record(level + 1, nest_pct);
      end else begin
         code = 16'($urandom);
         if (code == csr_model.nested_type) code = code ^ 16'h0001;
         put_word(start, code);
         len = ($urandom_range(7) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
         repeat (len) frame_q = {frame_q, 8'($urandom)};
      end
      put_word(start + 2, 16'(frame_q.size() - start - 4));
   endfunction

   // Build one random buffer: mostly well formed, some cut, damaged, padded or noise.
   function automatic void make_frame();
      int style;
      int nest_pct;
      int cut;
      frame_q.delete();
      style = $urandom_range(99);
      if (style < 5) begin
         repeat ($urandom_range(1, 12)) frame_q = {frame_q, 8'($urandom)};
      end else begin
         case ($urandom_range(2))
            0: nest_pct = 15;
            1: nest_pct = 50;
            default: nest_pct = 90;
         endcase
         repeat ($urandom_range(1, 3)) add_record(0, nest_pct);
         if (style < 15) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) void'(frame_q.pop_back());
         end else if (style < 25) begin
            frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom);
         end else if (style < 30) begin
            repeat ($urandom_range(1, 6)) frame_q = {frame_q, 8'($urandom)};
         end
      end
   endfunction

   // Offer one byte beat, with random idle cycles first, and predict on acceptance.
   task automatic send_byte(input logic [7:0] d, input bit last,
                            output bit has, output rsp_beat_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= d;
      req_chan.last_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      deframe_byte(d, last, has, r);
   endtask

   // Send the frame under construction, the last flag on its final byte.
   task automatic send_frame();
      bit           has;
      rsp_beat_type beat;
      for (int i = 0; i < frame_q.size(); i++) begin
         send_byte(frame_q[i], i == frame_q.size() - 1, has, beat);
         if (has) due_results = {due_results, beat};
      end
   endtask

   // Stop offering bytes and wait for the block to drain.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write a register, read it back, and update the mirrored copy.
   task automatic csr_write(input logic reg_idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         $display("%0t: register %0d readback expected 0x%0h, got 0x%0h",
                  $time, reg_idx, value, prdata);
         failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      if (reg_idx == REG_NESTED_TYPE) csr_model.nested_type = value[WORD_W-1:0];
      else csr_model.big_endian = value[0];
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         failures++;
      end
   endfunction

   // Compare an accepted result beat with the oldest expectation.
   task automatic check_beat();
      rsp_beat_type want;
      if (due_results.size() == 0) begin
         $display("%0t: result beat with none expected: kind %0d type 0x%0h offset %0d",
                  $time, rsp_chan.kind, rsp_chan.record_type, rsp_chan.value_offset);
         failures++;
      end else begin
         want = due_results.pop_front();
         check_field("kind", 16'(want.kind), 16'(rsp_chan.kind));
         check_field("record_type", want.record_type, rsp_chan.record_type);
         check_field("record_length", want.record_length, rsp_chan.record_length);
         check_field("value_offset", want.value_offset, rsp_chan.value_offset);
         check_field("nest_depth", 16'(want.nest_depth), 16'(rsp_chan.nest_depth));
      end
   endtask

   // Result side: check accepted beats and drive ready, with an occasional long hold.
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_beat();
         if (long_hold_len > 0) begin
            hold_left = long_hold_len;
            long_hold_len = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Main sequence: reset, hand-checked bytes, then random phases.
   initial begin : stimulus
      bit           has;
      rsp_beat_type beat;
      logic [15:0]  nest_code;
      logic         order;

      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= 8'h00;
      req_chan.last_byte <= 1'b0;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      csr_model.nested_type = 16'hFFFF;
      csr_model.big_endian  = 1'b0;
      clear_frame_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_bytes[i]) begin
         send_byte(opening_bytes[i].data, opening_bytes[i].last, has, beat);
         if (opening_bytes[i].typed) due_results = {due_results, opening_bytes[i].want};
         else if (has) due_results = {due_results, beat};
      end
      settle();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               tx_idle_pct = 0;  rx_stall_pct = 0;  nest_code = 16'hFFFF;     order = 1'b0;
            end
            1: begin
               tx_idle_pct = 64; rx_stall_pct = 0;  nest_code = 16'h0000;     order = 1'b1;
            end
            2: begin
               tx_idle_pct = 0;  rx_stall_pct = 64; nest_code = 16'($urandom); order = 1'b0;
            end
            3: begin
               tx_idle_pct = 31; rx_stall_pct = 31; nest_code = 16'($urandom); order = 1'b1;
            end
            default: begin
               tx_idle_pct = 0;  rx_stall_pct = 0;  nest_code = 16'($urandom); order = 1'b0;
            end
         endcase
         csr_write(REG_NESTED_TYPE, {16'h0000, nest_code});
         csr_write(REG_BIG_ENDIAN, {31'd0, order});

         // The result side holds off long enough for the block to stall its input.
         if (ph == 4) long_hold_len = 300;

         items_sent = 0;
         while (items_sent < PHASE_ITEMS) begin
            make_frame();
            send_frame();
         end
         settle();
      end

      if (failures == 0) begin
         $display("nested_tlv_deframer_unit regression: pass");
      end else begin
         $display("nested_tlv_deframer_unit regression: fail");
      end
      $finish;
   end

endmodule
